[design/imm_pkg.sv]
package imm_pkg;

    localparam int DEFAULT_MAX_DIM = 4;
    localparam int WORD_W          = 32;
    localparam int DIM_W           = 3;
    localparam int IDX_OUT_W       = 2;
    localparam int CFG_IDX_W       = 2;
    localparam logic [DIM_W-1:0] DIM_RESET = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS    = 2'd2;

    typedef enum logic [2:0] {
        S_LOAD,
        S_READ,
        S_MUL,
        S_ACC,
        S_EMIT
    } imm_state_t;

    typedef struct packed {
        logic wr_left;
        logic wr_right;
        logic rd_en;
        logic mul_en;
        logic acc_en;
        logic acc_first;
    } imm_ctrl_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] elem_value;
    } imm_in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]    product_value;
        logic        [IDX_OUT_W-1:0] out_row;
        logic        [IDX_OUT_W-1:0] out_col;
        logic                        last_result;
    } imm_out_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v, input int max_dim);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (int'(v) > max_dim)
        begin
            r = DIM_W'(max_dim);
        end
        return r;
    endfunction

endpackage

[design/imm_chan_if.sv]
interface imm_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[design/imm_datapath.sv]
module imm_datapath #(
    parameter int ADDR_W = 4
) (
    input  logic                                clk,
    input  imm_pkg::imm_ctrl_t                  ctrl,
    input  logic [ADDR_W-1:0]                   wr_addr,
    input  logic [imm_pkg::WORD_W-1:0]          wr_data,
    input  logic [ADDR_W-1:0]                   rd_left_addr,
    input  logic [ADDR_W-1:0]                   rd_right_addr,
    output logic signed [imm_pkg::WORD_W-1:0]   acc
);
    import imm_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    logic [WORD_W-1:0] left_mem  [DEPTH];
    logic [WORD_W-1:0] right_mem [DEPTH];
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] acc_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_left)
        begin
            left_mem[wr_addr] <= wr_data;
        end
        if (ctrl.wr_right)
        begin
            right_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            a_reg <= left_mem[rd_left_addr];
            b_reg <= right_mem[rd_right_addr];
        end
    end

    always_comb
    begin
        acc_next = (ctrl.acc_first ? '0 : acc_reg) + prod_reg;
    end

    // one shared multiply-accumulate, wraps modulo 2^32
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= a_reg * b_reg;
        end
        if (ctrl.acc_en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

[design/integer_matrix_multiply_unit.sv]
// loading: elements load at one per cycle with no result; after the last right element
// each product element is computed by a read, multiply and add per term through
// the single shared multiply-accumulate, then waits for the output transfer
// throughput: one element per cycle while loading, none until the last product is sent
// reset: dimensions return to 4 and the load position clears; stores keep no reset
module integer_matrix_multiply_unit #(
    parameter int MAX_DIM = imm_pkg::DEFAULT_MAX_DIM
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [imm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [imm_pkg::DIM_W-1:0]       cfg_data,
    imm_chan_if.sink                        elem,
    imm_chan_if.source                      product
);
    import imm_pkg::*;

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W = 2 * IDX_W;

    imm_state_t state_reg, state_next;

    logic [DIM_W-1:0] a_rows_reg, a_rows_next;
    logic [DIM_W-1:0] inner_reg, inner_next;
    logic [DIM_W-1:0] b_cols_reg, b_cols_next;

    logic [IDX_W-1:0] ld_row_reg, ld_row_next;
    logic [IDX_W-1:0] ld_col_reg, ld_col_next;
    logic             ld_right_reg, ld_right_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic [IDX_W-1:0] k_reg, k_next;

    logic [DIM_W-1:0] ar_m1, kd_m1, bc_m1;
    logic [DIM_W-1:0] ld_row_ext, ld_col_ext, row_ext, col_ext, k_ext;
    logic             in_xfer, out_xfer;
    logic             ld_row_end, ld_col_end, load_done;
    logic             row_end, col_end, k_end;

    imm_ctrl_t         ctrl;
    logic [ADDR_W-1:0] wr_addr, rd_left_addr, rd_right_addr;
    logic [WORD_W-1:0] acc;

    assign ar_m1 = eff_dim(a_rows_reg, MAX_DIM) - DIM_W'(1);
    assign kd_m1 = eff_dim(inner_reg, MAX_DIM) - DIM_W'(1);
    assign bc_m1 = eff_dim(b_cols_reg, MAX_DIM) - DIM_W'(1);

    assign ld_row_ext = DIM_W'(ld_row_reg);
    assign ld_col_ext = DIM_W'(ld_col_reg);
    assign row_ext    = DIM_W'(row_reg);
    assign col_ext    = DIM_W'(col_reg);
    assign k_ext      = DIM_W'(k_reg);

    assign in_xfer  = elem.valid && elem.ready;
    assign out_xfer = product.valid && product.ready;

    assign ld_col_end = ld_col_ext == (ld_right_reg ? bc_m1 : kd_m1);
    assign ld_row_end = ld_row_ext == (ld_right_reg ? kd_m1 : ar_m1);
    assign load_done  = in_xfer && ld_right_reg && ld_row_end && ld_col_end;

    assign row_end = row_ext == ar_m1;
    assign col_end = col_ext == bc_m1;
    assign k_end   = k_ext == kd_m1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            a_rows_reg   <= DIM_RESET;
            inner_reg    <= DIM_RESET;
            b_cols_reg   <= DIM_RESET;
            ld_row_reg   <= '0;
            ld_col_reg   <= '0;
            ld_right_reg <= 1'b0;
            row_reg      <= '0;
            col_reg      <= '0;
            k_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            a_rows_reg   <= a_rows_next;
            inner_reg    <= inner_next;
            b_cols_reg   <= b_cols_next;
            ld_row_reg   <= ld_row_next;
            ld_col_reg   <= ld_col_next;
            ld_right_reg <= ld_right_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            k_reg        <= k_next;
        end
    end

    // configuration registers
    always_comb
    begin
        a_rows_next = a_rows_reg;
        inner_next  = inner_reg;
        b_cols_next = b_cols_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_A_ROWS:    a_rows_next = cfg_data;
                REG_INNER_DIM: inner_next  = cfg_data;
                REG_B_COLS:    b_cols_next = cfg_data;
                default:       ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (load_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ: state_next = S_MUL;
            S_MUL:  state_next = S_ACC;
            S_ACC:  state_next = k_end ? S_EMIT : S_READ;
            S_EMIT:
            begin
                if (out_xfer)
                begin
                    state_next = (row_end && col_end) ? S_LOAD : S_READ;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    // load position and compute indices
    always_comb
    begin
        ld_row_next   = ld_row_reg;
        ld_col_next   = ld_col_reg;
        ld_right_next = ld_right_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        k_next        = k_reg;

        // any register write drops a partial load
        if (cfg_we)
        begin
            ld_row_next   = '0;
            ld_col_next   = '0;
            ld_right_next = 1'b0;
        end
        else if (in_xfer)
        begin
            if (ld_col_end)
            begin
                ld_col_next = '0;
                if (ld_row_end)
                begin
                    ld_row_next   = '0;
                    ld_right_next = !ld_right_reg;
                end
                else
                begin
                    ld_row_next = ld_row_reg + 1'b1;
                end
            end
            else
            begin
                ld_col_next = ld_col_reg + 1'b1;
            end
        end

        if (load_done)
        begin
            row_next = '0;
            col_next = '0;
            k_next   = '0;
        end
        else if (state_reg == S_ACC && !k_end)
        begin
            k_next = k_reg + 1'b1;
        end
        else if (state_reg == S_EMIT && out_xfer)
        begin
            k_next = '0;
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // outputs
    always_comb
    begin
        ctrl           = '0;
        elem.ready     = 1'b0;
        product.valid  = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                elem.ready     = 1'b1;
                ctrl.wr_left   = elem.valid && !ld_right_reg;
                ctrl.wr_right  = elem.valid && ld_right_reg;
            end
            S_READ: ctrl.rd_en = 1'b1;
            S_MUL:  ctrl.mul_en = 1'b1;
            S_ACC:
            begin
                ctrl.acc_en    = 1'b1;
                ctrl.acc_first = (k_reg == '0);
            end
            S_EMIT: product.valid = 1'b1;
            default: ;
        endcase
    end

    assign wr_addr       = {ld_row_reg, ld_col_reg};
    assign rd_left_addr  = {row_reg, k_reg};
    assign rd_right_addr = {k_reg, col_reg};

    assign product.payload.product_value = acc;
    assign product.payload.out_row       = row_ext[IDX_OUT_W-1:0];
    assign product.payload.out_col       = col_ext[IDX_OUT_W-1:0];
    assign product.payload.last_result   = row_end && col_end;

    imm_datapath #(
        .ADDR_W (ADDR_W)
    ) u_datapath (
        .clk           (clk),
        .ctrl          (ctrl),
        .wr_addr       (wr_addr),
        .wr_data       (elem.payload.elem_value),
        .rd_left_addr  (rd_left_addr),
        .rd_right_addr (rd_right_addr),
        .acc           (acc)
    );

endmodule
